>>> hdl/ddde_pkg.sv
// Shared field widths, constants and transfer types for the dot display delta encoder.
package ddde_pkg;

    localparam int COLUMN_W = 7;
    localparam int ROW_W    = 8;
    localparam int CMD_W    = 8;

    localparam int DEFAULT_PANEL_COLUMNS = 20;
    localparam int DEFAULT_PANEL_ROWS    = 120;

    // Bit 7 of the first command byte: new dot state is on
    localparam logic [CMD_W-1:0] DOT_SET_FLAG = 8'h80;

    typedef struct packed {
        logic                dot_on;
        logic [ROW_W-1:0]    row;
        logic [COLUMN_W-1:0] column;
    } dot_req_t;

    typedef struct packed {
        logic [CMD_W-1:0] command_second;
        logic [CMD_W-1:0] command_first;
    } panel_cmd_t;

endpackage

>>> hdl/ddde_shadow.sv
// Row-wide shadow memory of the panel with read-modify-write and change detection.
module ddde_shadow #(
    parameter int PANEL_COLUMNS = ddde_pkg::DEFAULT_PANEL_COLUMNS,
    parameter int PANEL_ROWS    = ddde_pkg::DEFAULT_PANEL_ROWS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  ddde_pkg::dot_req_t   req,
    output logic                 busy,
    output logic                 cmd_valid,
    output ddde_pkg::panel_cmd_t cmd
);

    localparam int CW = (PANEL_COLUMNS > 1) ? $clog2(PANEL_COLUMNS) : 1;
    localparam int RW = (PANEL_ROWS > 1) ? $clog2(PANEL_ROWS) : 1;
    localparam logic [ddde_pkg::COLUMN_W:0] COL_LIMIT = (ddde_pkg::COLUMN_W + 1)'(PANEL_COLUMNS);
    localparam logic [ddde_pkg::ROW_W:0]    ROW_LIMIT = (ddde_pkg::ROW_W + 1)'(PANEL_ROWS);

    typedef logic [PANEL_COLUMNS-1:0] row_bits_t;

    // One memory word per panel row, one bit per column
    row_bits_t mem [PANEL_ROWS];
    logic [PANEL_ROWS-1:0] row_valid_reg;

    logic                         in_range;
    logic [RW-1:0]                rd_idx;

    logic                         s1_valid_reg;
    logic [ddde_pkg::COLUMN_W-1:0] s1_col_reg;
    logic [ddde_pkg::ROW_W-1:0]   s1_row_reg;
    logic                         s1_on_reg;
    row_bits_t                    rd_data_reg;
    logic                         rd_vld_reg;

    logic                         wb_valid_reg;
    logic [RW-1:0]                wb_row_reg;
    row_bits_t                    wb_data_reg;

    logic                         fwd;
    row_bits_t                    cur_row;
    row_bits_t                    new_row;
    logic [CW-1:0]                s1_bit;
    logic [RW-1:0]                s1_idx;
    logic                         change;

    // Drop dots outside the panel before they touch the memory
    assign in_range = ({1'b0, req.column} < COL_LIMIT) && ({1'b0, req.row} < ROW_LIMIT);
    assign rd_idx   = req.row[RW-1:0];
    assign s1_idx   = s1_row_reg[RW-1:0];
    assign s1_bit   = s1_col_reg[CW-1:0];

    // Take the row written at the read edge; otherwise an unwritten row reads as all off
    always_comb
    begin
        fwd     = wb_valid_reg && (wb_row_reg == s1_idx);
        cur_row = fwd ? wb_data_reg : (rd_vld_reg ? rd_data_reg : '0);
        change  = s1_valid_reg && (cur_row[s1_bit] != s1_on_reg);
        new_row = cur_row;
        new_row[s1_bit] = s1_on_reg;
    end

    // Memory: read the requested row, write back a changed row
    always_ff @(posedge clk)
    begin
        if (req_valid && in_range)
        begin
            rd_data_reg <= mem[rd_idx];
        end
        if (change)
        begin
            mem[s1_idx] <= new_row;
        end
    end

    // Payload of the item in the modify stage and the last write-back
    always_ff @(posedge clk)
    begin
        if (req_valid && in_range)
        begin
            s1_col_reg <= req.column;
            s1_row_reg <= req.row;
            s1_on_reg  <= req.dot_on;
        end
        if (change)
        begin
            wb_row_reg  <= s1_idx;
            wb_data_reg <= new_row;
        end
    end

    // Control: stage valid, write-back valid and per-row valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            wb_valid_reg  <= 1'b0;
            rd_vld_reg    <= 1'b0;
            row_valid_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= req_valid && in_range;
            wb_valid_reg <= change;
            if (req_valid && in_range)
            begin
                rd_vld_reg <= row_valid_reg[rd_idx];
            end
            if (change)
            begin
                row_valid_reg[s1_idx] <= 1'b1;
            end
        end
    end

    assign busy      = s1_valid_reg;
    assign cmd_valid = change;
    assign cmd.command_first  = (s1_on_reg ? ddde_pkg::DOT_SET_FLAG : '0)
                              | {1'b0, s1_col_reg};
    assign cmd.command_second = s1_row_reg;

    // A command only ever comes from an item that sits in the modify stage
    a_cmd_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> s1_valid_reg)
        else $error("command without an item in the modify stage");

    // A write-back leaves its row marked as written
    a_row_marked: assert property (@(posedge clk) disable iff (!rst_n)
        change |=> row_valid_reg[wb_row_reg])
        else $error("written row not marked valid");

    // A command always flips the dot relative to what the shadow held
    a_flip: assert property (@(posedge clk) disable iff (!rst_n)
        change |-> (new_row != cur_row))
        else $error("command issued for an unchanged dot");

endmodule

>>> hdl/dot_display_delta_encoder.sv
// Top level of the dot display delta encoder: input stream, shadow update and command queue.
//
// Usage:
//   Input stream s_*: one wanted dot per transfer, s_tdata = column[6:0], row[14:7],
//   dot_on[15]. Output stream m_*: one panel command per transfer for each dot that
//   changes, m_tdata = command_first[7:0], command_second[15:8]. Dots outside the
//   panel, and dots already showing the wanted state, produce no transfer.
//   Throughput: one dot per cycle while s_tready is high, set by the single
//   read-modify-write of the row-wide shadow memory (read, then write back, with
//   forwarding of the last write for back-to-back dots on the same row).
//   Path: an accepted dot is registered into the modify stage, where its command is
//   formed and pushed into the command queue; m_tvalid rises once the queue holds it.
//   A two-entry command queue parts the sides; when the receiver stalls, s_tready
//   stays high until the queue plus the item in flight would fill it.
//   Reset: every dot reads as off. Each memory row carries a valid bit cleared at
//   reset, so the block is ready straight out of reset with no clearing pass.
module dot_display_delta_encoder #(
    parameter int PANEL_COLUMNS = ddde_pkg::DEFAULT_PANEL_COLUMNS,
    parameter int PANEL_ROWS    = ddde_pkg::DEFAULT_PANEL_ROWS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // column[6:0], row[14:7], dot_on[15]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // command_first[7:0], command_second[15:8]
);

    ddde_pkg::dot_req_t   req;
    ddde_pkg::panel_cmd_t cmd;
    logic                 accept;
    logic                 busy;
    logic                 cmd_valid;
    logic                 pop;

    ddde_pkg::panel_cmd_t queue_reg [2];
    logic [1:0]           count_reg;
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;

    assign req    = ddde_pkg::dot_req_t'(s_tdata);
    assign pop    = m_tvalid && m_tready;
    // Accept while the queue can still hold the item in flight and this one
    assign s_tready = (({1'b0, count_reg} + {2'b00, busy}) < (3'd2 + {2'b00, pop}));
    assign accept   = s_tvalid && s_tready;

    ddde_shadow #(
        .PANEL_COLUMNS (PANEL_COLUMNS),
        .PANEL_ROWS    (PANEL_ROWS)
    ) u_shadow (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (accept),
        .req       (req),
        .busy      (busy),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (cmd_valid)
        begin
            queue_reg[wr_ptr_reg] <= cmd;
        end
    end

    // Queue pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (cmd_valid)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, cmd_valid} - {1'b0, pop};
        end
    end

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = queue_reg[rd_ptr_reg];

    // Never push into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> (count_reg != 2'd2))
        else $error("command queue overflow");

    // Fill level stays within the two entries
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("command queue count out of range");

    // A full queue with an item in flight must hold off the input
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && !pop) |-> !s_tready)
        else $error("input accepted with no room for its command");

endmodule
